/* rtl/core/lts_pkg.sv */
//------------------------------------------------------------------------------
// lts_pkg
// Shared types and constants for the lidar intercept-time sector watcher.
//------------------------------------------------------------------------------
package lts_pkg;

  localparam int MinW   = 7;
  localparam logic [MinW-1:0] MinStart = 7'd100;
  localparam logic [4:0] SearchStart = 5'd20;

  // register indexes
  localparam logic [1:0] RegCruise = 2'd0;
  localparam logic [1:0] RegSteer  = 2'd1;
  localparam logic [1:0] RegLimit  = 2'd2;
  localparam logic [1:0] RegHold   = 2'd3;

  // manoeuvre modes
  localparam logic [2:0] ModeSearch   = 3'd0;
  localparam logic [2:0] ModeFwd      = 3'd1;
  localparam logic [2:0] ModeRev      = 3'd2;
  localparam logic [2:0] ModeLeft     = 3'd3;
  localparam logic [2:0] ModeRight    = 3'd4;
  localparam logic [2:0] ModeRevLeft  = 3'd5;
  localparam logic [2:0] ModeRevRight = 3'd6;

  // quotient bits: a beam within the limit (below 128 s) has n*2^14/d < 2^7,
  // so eight restoring steps cover every quotient that is kept
  localparam int QBits = 8;

  typedef struct packed {
    logic scan_end;   // run manoeuvre update, reload minima
  } lts_cmd_t;

  typedef struct packed {
    logic busy;
  } lts_status_t;

  function automatic logic [2:0] fallback(input logic [2:0] m, input int k);
    logic [2:0] r;
    r = ModeSearch;
    case (m)
      ModeFwd:      case (k) 0: r = ModeLeft; 1: r = ModeRight; 2: r = ModeRev;
                      3: r = ModeRevLeft; default: r = ModeRevRight; endcase
      ModeRev:      case (k) 0: r = ModeRevLeft; 1: r = ModeRevRight; 2: r = ModeFwd;
                      3: r = ModeLeft; default: r = ModeRight; endcase
      ModeLeft:     case (k) 0: r = ModeFwd; 1: r = ModeRight; 2: r = ModeRev;
                      3: r = ModeRevLeft; default: r = ModeRevRight; endcase
      ModeRight:    case (k) 0: r = ModeFwd; 1: r = ModeLeft; 2: r = ModeRev;
                      3: r = ModeRevLeft; default: r = ModeRevRight; endcase
      ModeRevLeft:  case (k) 0: r = ModeFwd; 1: r = ModeRevRight; 2: r = ModeRev;
                      3: r = ModeLeft; default: r = ModeRight; endcase
      ModeRevRight: case (k) 0: r = ModeFwd; 1: r = ModeRevLeft; 2: r = ModeRev;
                      3: r = ModeLeft; default: r = ModeRight; endcase
      default:      r = ModeSearch;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/lts_if.sv */
//------------------------------------------------------------------------------
// lts_beam_if / lts_cmd_if
// Valid/ready channels for beams in and drive commands out.
//------------------------------------------------------------------------------
interface lts_beam_if;
  logic               valid;
  logic               ready;
  logic [10:0]        beam_index;
  logic [15:0]        range_mm;
  logic [15:0]        edge_mm;
  logic signed [15:0] cos_q14;
  logic signed [15:0] speed_mm_s;
  logic               last_beam;
  modport source (output valid, beam_index, range_mm, edge_mm, cos_q14, speed_mm_s,
                  last_beam, input ready);
  modport sink (input valid, beam_index, range_mm, edge_mm, cos_q14, speed_mm_s,
                last_beam, output ready);
endinterface

interface lts_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] speed_cmd;
  logic signed [9:0]  steer_cmd;
  logic [2:0]         mode;
  logic               braking;
  modport source (output valid, speed_cmd, steer_cmd, mode, braking, input ready);
  modport sink (input valid, speed_cmd, steer_cmd, mode, braking, output ready);
endinterface

/* rtl/core/lidar_ttc_sector_avoidance_core.sv */
//------------------------------------------------------------------------------
// lidar_ttc_sector_avoidance_core
// Lidar intercept-time sector watcher with a seven-mode avoidance manoeuvre.
//------------------------------------------------------------------------------
// A beam that falls in one of the six sectors and is closing in runs the
// restoring divider before the next beam can be accepted: a setup step for
// the limit check, eight quotient bits, then the minimum update. Any other
// beam skips the divider. The last beam of a scan also passes through the
// manoeuvre update, and its drive command waits in an output register until
// taken; beams keep flowing meanwhile, and only the close of the following
// scan holds until that command is gone.
module lidar_ttc_sector_avoidance_core import lts_pkg::*; #(
  parameter int BEAMS = 1080,
  parameter int FRONT_SECTOR_BEAMS = 15,
  parameter int REAR_SECTOR_BEAMS = 16,
  parameter int WIDE_SECTOR_BEAMS = 76
) (
  input  logic        clk,
  input  logic        rst,
  lts_beam_if.sink    beam,
  lts_cmd_if.source   cmd,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [14:0] cruise_speed, intercept_limit;
  logic [9:0]  max_steer;
  logic [7:0]  brake_hold_scans;
  logic        load;
  lts_cmd_t    ctl;
  lts_status_t st;

  assign pready = 1'b1;

  lts_cfg u_cfg (.clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .cruise_speed, .max_steer, .intercept_limit, .brake_hold_scans);

  lts_ctrl u_ctrl (.clk, .rst, .in_valid(beam.valid), .in_ready(beam.ready),
    .in_last(beam.last_beam), .load, .cmd(ctl), .status(st),
    .out_valid(cmd.valid), .out_ready(cmd.ready));

  lts_dp #(.BEAMS(BEAMS), .FRONT_SECTOR_BEAMS(FRONT_SECTOR_BEAMS),
    .REAR_SECTOR_BEAMS(REAR_SECTOR_BEAMS), .WIDE_SECTOR_BEAMS(WIDE_SECTOR_BEAMS)) u_dp (
    .clk, .rst, .load, .beam_index(beam.beam_index), .range_mm(beam.range_mm),
    .edge_mm(beam.edge_mm), .cos_q14(beam.cos_q14), .speed_mm_s(beam.speed_mm_s),
    .cmd(ctl), .status(st), .cruise_speed, .max_steer, .intercept_limit,
    .brake_hold_scans, .speed_cmd(cmd.speed_cmd), .steer_cmd(cmd.steer_cmd),
    .mode(cmd.mode), .braking(cmd.braking));
endmodule

/* rtl/core/lts_ctrl.sv */
//------------------------------------------------------------------------------
// lts_ctrl
// Sequencer: accept a beam, run the divider, close the scan, hand off result.
//------------------------------------------------------------------------------
module lts_ctrl import lts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_last,
  output logic        load,
  output lts_cmd_t    cmd,
  input  lts_status_t status,
  output logic        out_valid,
  input  logic        out_ready
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StEnd  = 2'd2;

  logic [1:0] state, state_next;
  logic       last_q;
  logic       acc;

  // take a beam whenever idle; a waiting command only holds the next scan close
  assign in_ready = (state == StIdle);
  assign acc      = in_valid && in_ready;
  assign load     = acc;
  assign cmd.scan_end = (state == StEnd);

  always_comb begin
    state_next = state;
    case (state)
      StIdle: if (acc) state_next = StDiv;
      StDiv: if (!status.busy) begin
        if (!last_q) state_next = StIdle;
        else if (!out_valid || out_ready) state_next = StEnd;
      end
      StEnd:  state_next = StIdle;
      default: state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StIdle;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == StEnd) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) last_q <= in_last;
  end
endmodule

/* rtl/core/lts_dp.sv */
//------------------------------------------------------------------------------
// lts_dp
// Datapath: sector decode, serial divider, sector minima, manoeuvre update.
//------------------------------------------------------------------------------
module lts_dp import lts_pkg::*; #(
  parameter int BEAMS = 1080,
  parameter int FRONT_SECTOR_BEAMS = 15,
  parameter int REAR_SECTOR_BEAMS = 16,
  parameter int WIDE_SECTOR_BEAMS = 76
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic [10:0]        beam_index,
  input  logic [15:0]        range_mm,
  input  logic [15:0]        edge_mm,
  input  logic signed [15:0] cos_q14,
  input  logic signed [15:0] speed_mm_s,
  input  lts_cmd_t           cmd,
  output lts_status_t        status,
  input  logic [14:0]        cruise_speed,
  input  logic [9:0]         max_steer,
  input  logic [14:0]        intercept_limit,
  input  logic [7:0]         brake_hold_scans,
  output logic signed [15:0] speed_cmd,
  output logic signed [9:0]  steer_cmd,
  output logic [2:0]         mode,
  output logic               braking
);
  localparam int C = BEAMS / 2;

  // sector decode and sign test, registered at load
  logic [11:0] b;
  logic [2:0]  sec;
  logic signed [16:0] diff;
  logic signed [31:0] den;
  logic [15:0] n_abs;
  logic [30:0] d_abs;
  logic        cand_c;

  assign b    = {1'b0, beam_index};
  assign diff = $signed({1'b0, range_mm}) - $signed({1'b0, edge_mm});
  assign den  = speed_mm_s * cos_q14;
  assign n_abs = diff[16] ? 16'(-diff) : diff[15:0];
  assign d_abs = den[31] ? 31'(-den) : den[30:0];

  always_comb begin
    sec = 3'd7;
    if (int'(b) >= C-FRONT_SECTOR_BEAMS+1 && int'(b) <= C) sec = 3'd0;
    else if (int'(b) >= C+1 && int'(b) <= C+FRONT_SECTOR_BEAMS) sec = 3'd1;
    else if (int'(b) >= C-FRONT_SECTOR_BEAMS-WIDE_SECTOR_BEAMS+1 &&
             int'(b) <= C-FRONT_SECTOR_BEAMS) sec = 3'd2;
    else if (int'(b) >= C+FRONT_SECTOR_BEAMS+1 &&
             int'(b) <= C+FRONT_SECTOR_BEAMS+WIDE_SECTOR_BEAMS) sec = 3'd3;
    else if (int'(b) >= 1 && int'(b) <= REAR_SECTOR_BEAMS) sec = 3'd4;
    else if (int'(b) >= BEAMS-REAR_SECTOR_BEAMS+1 && int'(b) <= BEAMS-1) sec = 3'd5;
  end
  assign cand_c = (sec != 3'd7) && (diff != 0) && (den != 0) && (diff[16] == den[31]);

  // restoring divider of n*2^14 by d, one quotient bit a cycle, after a
  // setup step that checks n*2^22 <= L*d and preloads n*2^14 >> QBits
  logic [2:0]  sec_q;
  logic        cand_q;
  logic [15:0] n_q;
  logic [30:0] dq;
  logic [31:0] rem;
  logic [QBits-1:0] quo;
  logic [3:0]  cnt;
  logic        in_limit;
  logic [45:0] lim_prod;
  logic [31:0] rem_try;

  assign lim_prod = {31'd0, intercept_limit} * {15'd0, dq};
  // the low bits of n*2^14 below the preload are all zero
  assign rem_try = {rem[30:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= cand_c ? 4'(QBits + 1) : 4'd0;
    end else if (cnt != 0) begin
      cnt <= cnt - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sec_q  <= sec;
      cand_q <= cand_c;
      n_q    <= n_abs;
      dq     <= d_abs;
      rem    <= '0;
      quo    <= '0;
      in_limit <= 1'b0;
    end else if (cnt == 4'(QBits + 1)) begin
      in_limit <= ({8'd0, n_q, 22'd0} <= lim_prod);
      // stays below d whenever the limit holds
      rem <= 32'({n_q, 14'd0}) >> QBits;
    end else if (cnt != 0) begin
      if ({1'b0, rem_try} >= {2'b0, dq}) begin
        rem <= rem_try - {1'b0, dq};
        quo <= {quo[QBits-2:0], 1'b1};
      end else begin
        rem <= rem_try;
        quo <= {quo[QBits-2:0], 1'b0};
      end
    end
  end

  assign status.busy = (cnt != 0);

  // sector minima
  logic [MinW-1:0] smin [6];
  logic upd_done;
  always_ff @(posedge clk) begin
    if (rst) upd_done <= 1'b0;
    else upd_done <= (cnt == 4'd1);
  end

  // manoeuvre state
  logic [2:0] mstate;
  logic       brk;
  logic [7:0] bcnt;
  logic [4:0] sth;
  logic [8:0] fa, wa, ba;
  logic [7:0] wl, wr, bl, br;
  logic [6:0] ok;
  logic       trig;
  logic [2:0] nm;
  logic       found;
  logic [2:0] pick;
  logic       hold;
  logic [8:0] f9;

  function automatic logic [8:0] pavg(input logic [6:0] l, input logic [6:0] r);
    logic [7:0] s;
    s = {1'b0, l} + {1'b0, r};
    return (l >= r) ? {2'b0, s[7:1]} : {2'b0, l};
  endfunction

  assign fa = pavg(smin[0], smin[1]);
  assign wa = pavg(smin[2], smin[3]);
  assign ba = pavg(smin[4], smin[5]);
  assign wl = {1'b0, smin[2]};
  assign wr = {1'b0, smin[3]};
  assign bl = {1'b0, smin[4]};
  assign br = {1'b0, smin[5]};
  assign f9 = {4'd0, sth};

  always_comb begin
    ok[0] = 1'b0;
    ok[1] = ({fa, 2'b0} > 11'd5);
    ok[2] = ({ba, 2'b0} > 11'd5);
    ok[3] = wl > 8'd1;
    ok[4] = wr > 8'd1;
    ok[5] = bl > 8'd1;
    ok[6] = br > 8'd1;
    case (mstate)
      ModeFwd:     trig = {fa, 2'b0} < 11'd5;
      ModeRev:     trig = {ba, 2'b0} < 11'd5;
      ModeLeft:    trig = {wl, 2'b0} < 10'd5;
      ModeRight:   trig = {wr, 2'b0} < 10'd5;
      ModeRevLeft: trig = bl < 8'd1;
      ModeRevRight: trig = br < 8'd1;
      default:     trig = 1'b0;
    endcase
    nm = ModeSearch;
    found = 1'b0;
    for (int k = 4; k >= 0; k--) begin
      if (ok[fallback(mstate, k)]) begin
        nm = fallback(mstate, k);
        found = 1'b1;
      end
    end
    hold = 1'b0;
    pick = ModeSearch;
    if (13'(fa * 10) > 13'(f9)) pick = ModeFwd;
    else if (13'(ba * 10) > 13'(f9)) pick = ModeRev;
    else if (13'(wa * 10) > 13'(f9)) begin
      if (13'(wl * 10) > 13'(f9)) pick = ModeLeft;
      else if (13'(wr * 10) > 13'(f9)) pick = ModeRight;
      else hold = 1'b1;
    end
    else if (13'(bl * 10) >= 13'(f9)) pick = ModeRevLeft;
    else if (13'(br * 10) >= 13'(f9)) pick = ModeRevRight;
  end

  function automatic logic [1:0] fsgn(input logic [2:0] m);
    case (m)
      ModeFwd, ModeLeft, ModeRight: return 2'b01;
      ModeRev, ModeRevLeft, ModeRevRight: return 2'b11;
      default: return 2'b00;
    endcase
  endfunction
  function automatic logic [1:0] tsgn(input logic [2:0] m);
    case (m)
      ModeLeft, ModeRevLeft: return 2'b11;
      ModeRight, ModeRevRight: return 2'b01;
      default: return 2'b00;
    endcase
  endfunction

  logic [1:0] fs, ts;
  logic [1:0] fs_n, ts_n;
  logic [2:0] m_n;
  logic       brk_n;
  logic [7:0] bcnt_n;
  logic [4:0] sth_n;
  logic       out_brk;

  always_comb begin
    fs_n = fs; ts_n = ts; m_n = mstate; brk_n = brk; bcnt_n = bcnt; sth_n = sth;
    out_brk = brk;
    if (brk) begin
      bcnt_n = bcnt + 8'd1;
      if (bcnt_n > brake_hold_scans) begin
        bcnt_n = 8'd0;
        brk_n  = 1'b0;
      end
    end else if (mstate != ModeSearch) begin
      if (trig) begin
        brk_n = 1'b1;
        m_n = nm;
        if (found) begin
          fs_n = fsgn(nm);
          ts_n = tsgn(nm);
        end
      end
    end else if (!hold) begin
      if (pick != ModeSearch) begin
        sth_n = SearchStart;
        m_n = pick;
        fs_n = fsgn(pick);
        ts_n = tsgn(pick);
      end else if (sth >= 5'd3) begin
        sth_n = sth - 5'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) smin[i] <= MinStart;
      mstate <= ModeSearch;
      brk <= 1'b0;
      bcnt <= '0;
      sth <= SearchStart;
      fs <= '0;
      ts <= '0;
    end else if (cmd.scan_end) begin
      for (int i = 0; i < 6; i++) smin[i] <= MinStart;
      mstate <= m_n; brk <= brk_n; bcnt <= bcnt_n; sth <= sth_n; fs <= fs_n; ts <= ts_n;
      braking <= out_brk;
      mode    <= m_n;
      if (out_brk) begin
        speed_cmd <= '0;
        steer_cmd <= '0;
      end else begin
        speed_cmd <= fs_n == 2'b01 ? $signed({1'b0, cruise_speed}) :
                     fs_n == 2'b11 ? -$signed({1'b0, cruise_speed}) : '0;
        steer_cmd <= ts_n == 2'b01 ? $signed({1'b0, max_steer[9:1]}) :
                     ts_n == 2'b11 ? -$signed({1'b0, max_steer[9:1]}) : '0;
      end
    end else if (upd_done && cand_q && in_limit) begin
      if ({1'b0, quo} < {2'b0, smin[sec_q]}) smin[sec_q] <= quo[MinW-1:0];
    end
  end
endmodule

/* rtl/core/lts_cfg.sv */
//------------------------------------------------------------------------------
// lts_cfg
// APB register file for the four configuration registers.
//------------------------------------------------------------------------------
module lts_cfg import lts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic [14:0] cruise_speed,
  output logic [9:0]  max_steer,
  output logic [14:0] intercept_limit,
  output logic [7:0]  brake_hold_scans
);
  logic [1:0] idx;
  assign idx = paddr[3:2];
  always_ff @(posedge clk) begin
    if (rst) begin
      cruise_speed <= 15'd2000;
      max_steer <= 10'd419;
      intercept_limit <= 15'd512;
      brake_hold_scans <= 8'd50;
    end else if (psel && penable && pwrite) begin
      case (idx)
        RegCruise: cruise_speed <= pwdata[14:0];
        RegSteer:  max_steer <= pwdata[9:0];
        RegLimit:  intercept_limit <= pwdata[14:0];
        RegHold:   brake_hold_scans <= pwdata[7:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (idx)
      RegCruise: prdata = {17'd0, cruise_speed};
      RegSteer:  prdata = {22'd0, max_steer};
      RegLimit:  prdata = {17'd0, intercept_limit};
      RegHold:   prdata = {24'd0, brake_hold_scans};
      default:   prdata = '0;
    endcase
  end
endmodule

/* rtl/core/lts_checker.sv */
//------------------------------------------------------------------------------
// lts_sva_checker
// Port-level checks on the command channel.
//------------------------------------------------------------------------------
module lts_sva_checker import lts_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        braking,
  input logic signed [15:0] speed_cmd,
  input logic [2:0]  mode
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("command dropped");
  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(speed_cmd) && $stable(mode) && $stable(braking))
    else $error("command changed while waiting");
  a_brk: assert property (@(posedge clk) disable iff (rst)
    out_valid && braking |-> speed_cmd == 0) else $error("braking moves");
  a_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> mode <= ModeRevRight) else $error("bad mode");
endmodule

bind lidar_ttc_sector_avoidance_core lts_sva_checker u_chk (.clk, .rst,
  .out_valid(cmd.valid), .out_ready(cmd.ready),
  .braking(cmd.braking), .speed_cmd(cmd.speed_cmd), .mode(cmd.mode));
